// ===== hw/rtl/grap_pkg.sv =====
// Shared types and constants for the elliptical Gaussian ring pixel pipeline.
// No dependencies; every other file imports this package.
package grap_pkg;

	// CORDIC iteration count and internal CORDIC word width
	localparam int CORDIC_STEPS = 16;
	localparam int CW           = 34;
	// Width of the pixel offsets from the ring centre (signed Q.8)
	localparam int DW           = 26;

	// Queue between the front and the back end
	localparam int FIFO_DEPTH = 4;
	localparam int FIFO_AW    = 2;

	// Latency of the exponential unit and of the whole back end
	localparam int EXP_TERMS = 14;
	localparam int EXP_POWS  = 16;
	localparam int EXP_LAT   = 2 + 3 * EXP_TERMS + 1 + EXP_POWS;
	localparam int BACK_LAT  = 2 * CORDIC_STEPS + 7 + EXP_LAT;

	// Angles in 1/2^32 turn, gain compensation and e^-1 in fixed point
	localparam logic signed [CW-1:0] ANG_HALF    = CW'(64'sd2147483648);
	localparam logic signed [CW-1:0] ANG_QUARTER = CW'(64'sd1073741824);
	localparam logic signed [CW-1:0] KINV_Q30    = CW'(64'sd652032874);
	localparam logic [29:0]          EINV_Q31    = 30'd790015084;

	// arctan(2^-i) in 1/2^32 turn
	localparam logic [31:0] ATAN_TAB [32] = '{
		32'd536870912, 32'd316933406, 32'd167458907, 32'd85004756,
		32'd42667331,  32'd21354465,  32'd10679838,  32'd5340245,
		32'd2670163,   32'd1335087,   32'd667544,    32'd333772,
		32'd166886,    32'd83443,     32'd41722,     32'd20861,
		32'd10430,     32'd5215,      32'd2608,      32'd1304,
		32'd652,       32'd326,       32'd163,       32'd81,
		32'd41,        32'd20,        32'd10,        32'd5,
		32'd3,         32'd1,         32'd1,         32'd0
	};

	// Configuration register indexes
	typedef enum logic [2:0] {
		REG_CENTER_X    = 3'd0,
		REG_CENTER_Y    = 3'd1,
		REG_PA_ANGLE    = 3'd2,
		REG_INV_AXIS    = 3'd3,
		REG_RING_RADIUS = 3'd4,
		REG_INV_2SIGSQ  = 3'd5,
		REG_AMP_MID     = 3'd6,
		REG_AMP_DELTA   = 3'd7
	} cfg_reg_t;

	// One classified pixel as queued between front and back
	typedef struct packed {
		logic signed [DW-1:0] dx;
		logic signed [DW-1:0] dy;
		logic                 zero;
	} item_t;

endpackage

// ===== hw/rtl/gaussian_ring_azimuthal_pixel.sv =====
// Top level of the elliptical Gaussian ring pixel model.
// Depends on grap_pkg, grap_front, grap_fifo, grap_cordic_rot, grap_cordic_vec, grap_exp.
//
// Usage:
//   Input stream s_*: one pixel coordinate per beat. Output stream m_*: one model
//   intensity beat per input beat, in the same order.
//   Configuration: cfg_we writes cfg_data to the register selected by cfg_index
//   (centre, position angle, 1/q, ring radius, 1/(2 sigma^2), amplitudes).
//   Write registers only while no pixel is in flight.
// Throughput: one pixel per cycle unless stalled. The back end is a fully pipelined
//   chain of two CORDIC rows, the multiply stages and the exponential unit.
// Path: from the queue head through both CORDIC rows, the multiply stages and the
//   exponential unit into the output register; the front queue lies before it.
// Reset: the queue and all pipeline valid bits are cleared; registers take their
//   default values (position angle a quarter turn, 1/q one, 1/(2 sigma^2) one LSB).
// Stall: while the output register holds a beat and m_tready is low the back end
//   holds; the four-entry queue keeps taking pixels until it is full, then s_tready drops.
module gaussian_ring_azimuthal_pixel (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [31:0] s_tdata,   // pixel_x [15:0], pixel_y [31:16]
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [31:0] m_tdata,   // intensity [31:0]
	input  logic        cfg_we,
	input  logic [2:0]  cfg_index,
	input  logic [31:0] cfg_data
);
	import grap_pkg::*;

	// Configuration registers
	logic [23:0] center_x_q;
	logic [23:0] center_y_q;
	logic [15:0] pa_angle_q;
	logic [19:0] inv_axis_q;
	logic [23:0] ring_radius_q;
	logic [31:0] inv_2sigsq_q;
	logic [31:0] amp_mid_q;
	logic [31:0] amp_delta_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			center_x_q    <= '0;
			center_y_q    <= '0;
			pa_angle_q    <= 16'd16384;
			inv_axis_q    <= 20'd65536;
			ring_radius_q <= '0;
			inv_2sigsq_q  <= 32'd1;
			amp_mid_q     <= '0;
			amp_delta_q   <= '0;
		end else if (cfg_we) begin
			unique case (cfg_reg_t'(cfg_index))
				REG_CENTER_X:    center_x_q    <= cfg_data[23:0];
				REG_CENTER_Y:    center_y_q    <= cfg_data[23:0];
				REG_PA_ANGLE:    pa_angle_q    <= cfg_data[15:0];
				REG_INV_AXIS:    inv_axis_q    <= cfg_data[19:0];
				REG_RING_RADIUS: ring_radius_q <= cfg_data[23:0];
				REG_INV_2SIGSQ:  inv_2sigsq_q  <= cfg_data;
				REG_AMP_MID:     amp_mid_q     <= cfg_data;
				REG_AMP_DELTA:   amp_delta_q   <= cfg_data;
				default: ;
			endcase
		end
	end

	// Front end and queue
	item_t front_item;
	item_t head;
	logic  q_full;
	logic  q_empty;
	logic  en;
	logic  pop;

	grap_front u_front (
		.pixel_x  (s_tdata[15:0]),
		.pixel_y  (s_tdata[31:16]),
		.center_x (center_x_q),
		.center_y (center_y_q),
		.item     (front_item)
	);

	assign s_tready = !q_full;

	grap_fifo u_fifo (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (s_tvalid && !q_full),
		.wdata  (front_item),
		.pop    (pop),
		.rdata  (head),
		.full   (q_full),
		.empty  (q_empty)
	);

	// Back end advances whenever the output register is free or being emptied
	logic m_tvalid_q;
	assign en  = !m_tvalid_q || m_tready;
	assign pop = en && !q_empty;

	logic [BACK_LAT-1:0] v_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_q <= '0;
		end else if (en) begin
			v_q <= {v_q[BACK_LAT-2:0], !q_empty};
		end
	end

	// First CORDIC row: position angle rotation and image angle
	logic [31:0]          pa32;
	logic signed [CW-1:0] c_pa, s_pa;
	logic signed [CW-1:0] mag_img;
	logic [31:0]          theta_raw;

	assign pa32 = {pa_angle_q, 16'h0000};

	grap_cordic_rot u_rot_pa (
		.clk   (clk),
		.en    (en),
		.x_in  (KINV_Q30),
		.y_in  ('0),
		.z_in  ($signed(pa32)),
		.x_out (c_pa),
		.y_out (s_pa)
	);

	grap_cordic_vec u_vec_img (
		.clk   (clk),
		.en    (en),
		.x_in  (CW'(head.dx)),
		.y_in  (CW'(head.dy)),
		.mag   (mag_img),
		.angle (theta_raw)
	);

	// Offsets travel beside the first row
	item_t dly_q [CORDIC_STEPS];
	item_t dly_out;

	always_ff @(posedge clk) begin
		if (en) begin
			dly_q[0] <= head;
			for (int i = 1; i < CORDIC_STEPS; i++) begin
				dly_q[i] <= dly_q[i-1];
			end
		end
	end

	assign dly_out = dly_q[CORDIC_STEPS-1];

	// Rotation products and doubled relative angle
	logic signed [59:0] pdxc_s1, pdys_s1, pdyc_s1, pdxs_s1;
	logic [31:0]        twice_s1;
	logic [31:0]        theta;
	logic [31:0]        adiff;

	assign theta = dly_out.zero ? 32'h0 : theta_raw;
	assign adiff = pa32 - theta;

	always_ff @(posedge clk) begin
		if (en) begin
			pdxc_s1  <= dly_out.dx * c_pa;
			pdys_s1  <= dly_out.dy * s_pa;
			pdyc_s1  <= dly_out.dy * c_pa;
			pdxs_s1  <= dly_out.dx * s_pa;
			twice_s1 <= {adiff[30:0], 1'b0};
		end
	end

	// Rotated coordinates
	logic signed [60:0] xsum, ysum;
	logic signed [30:0] xp_s2, yp_s2;
	logic [31:0]        twice_s2;

	assign xsum = 61'(pdxc_s1) + 61'(pdys_s1);
	assign ysum = 61'(pdyc_s1) - 61'(pdxs_s1);

	always_ff @(posedge clk) begin
		if (en) begin
			xp_s2    <= xsum[60:30];
			yp_s2    <= ysum[60:30];
			twice_s2 <= twice_s1;
		end
	end

	// Minor axis scaled by 1/q
	logic signed [51:0]   yprod;
	logic signed [30:0]   xp_s3;
	logic signed [CW-1:0] yps_s3;
	logic [31:0]          twice_s3;

	assign yprod = yp_s2 * $signed({1'b0, inv_axis_q});

	always_ff @(posedge clk) begin
		if (en) begin
			xp_s3    <= xp_s2;
			yps_s3   <= yprod[CW+15:16];
			twice_s3 <= twice_s2;
		end
	end

	// Second CORDIC row: elliptical radius and cos of twice the angle
	logic signed [CW-1:0] mag_ell;
	logic [31:0]          ang_unused;
	logic signed [CW-1:0] c2, s2;

	grap_cordic_vec u_vec_ell (
		.clk   (clk),
		.en    (en),
		.x_in  (CW'(xp_s3)),
		.y_in  (yps_s3),
		.mag   (mag_ell),
		.angle (ang_unused)
	);

	grap_cordic_rot u_rot_az (
		.clk   (clk),
		.en    (en),
		.x_in  (KINV_Q30),
		.y_in  ('0),
		.z_in  ($signed(twice_s3)),
		.x_out (c2),
		.y_out (s2)
	);

	// Gain compensation and azimuthal product
	logic signed [64:0] magk_s4;
	logic signed [65:0] dprod_s4;

	always_ff @(posedge clk) begin
		if (en) begin
			magk_s4  <= mag_ell * KINV_Q30;
			dprod_s4 <= $signed(amp_delta_q) * c2;
		end
	end

	// Radial offset and clamped amplitude
	logic signed [34:0] rdiff;
	logic signed [36:0] asum;
	logic signed [31:0] d_s5;
	logic signed [32:0] amp_s5;

	assign rdiff = magk_s4[64:30] - $signed({11'h0, ring_radius_q});
	assign asum  = 37'($signed(amp_mid_q)) + 37'($signed(dprod_s4[65:30]));

	always_ff @(posedge clk) begin
		if (en) begin
			d_s5 <= rdiff[31:0];
			if (asum > 37'sd4294967295) begin
				amp_s5 <= 33'sd4294967295;
			end else if (asum < -37'sd4294967295) begin
				amp_s5 <= -33'sd4294967295;
			end else begin
				amp_s5 <= asum[32:0];
			end
		end
	end

	// Squared offset
	logic signed [63:0] dsq;
	logic [61:0]        u_s6;
	logic signed [32:0] amp_s6;

	assign dsq = d_s5 * d_s5;

	always_ff @(posedge clk) begin
		if (en) begin
			u_s6   <= dsq[61:0];
			amp_s6 <= amp_s5;
		end
	end

	// Gaussian factor
	logic [31:0]        gfac;
	logic signed [32:0] amp_e;

	grap_exp u_exp (
		.clk     (clk),
		.en      (en),
		.u       (u_s6),
		.k       (inv_2sigsq_q),
		.amp_in  (amp_s6),
		.g       (gfac),
		.amp_out (amp_e)
	);

	// Amplitude times Gaussian
	logic signed [65:0] prod_s7;

	always_ff @(posedge clk) begin
		if (en) begin
			prod_s7 <= amp_e * $signed({1'b0, gfac});
		end
	end

	// Saturate into the output register
	logic signed [34:0] res;
	logic [31:0]        m_tdata_q;

	assign res = prod_s7[65:31];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid_q <= 1'b0;
		end else if (en) begin
			m_tvalid_q <= v_q[BACK_LAT-1];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			if (res > 35'sd2147483647) begin
				m_tdata_q <= 32'h7FFF_FFFF;
			end else if (res < -35'sd2147483648) begin
				m_tdata_q <= 32'h8000_0000;
			end else begin
				m_tdata_q <= res[31:0];
			end
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = m_tdata_q;

endmodule

// ===== hw/rtl/grap_front.sv =====
// Front end: turns an input pixel into centre offsets and flags the on-centre case.
// Depends on grap_pkg.
module grap_front (
	input  logic [15:0]     pixel_x,
	input  logic [15:0]     pixel_y,
	input  logic [23:0]     center_x,
	input  logic [23:0]     center_y,
	output grap_pkg::item_t item
);
	import grap_pkg::*;

	logic signed [DW-1:0] dx;
	logic signed [DW-1:0] dy;

	// Offsets in Q.8 pixels
	assign dx = $signed({2'b00, pixel_x, 8'h00}) - $signed({2'b00, center_x});
	assign dy = $signed({2'b00, pixel_y, 8'h00}) - $signed({2'b00, center_y});

	assign item.dx   = dx;
	assign item.dy   = dy;
	assign item.zero = (dx == '0) && (dy == '0);

endmodule

// ===== hw/rtl/grap_fifo.sv =====
// Short queue of classified pixels between the front and back ends.
// Depends on grap_pkg.
module grap_fifo (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            push,
	input  grap_pkg::item_t wdata,
	input  logic            pop,
	output grap_pkg::item_t rdata,
	output logic            full,
	output logic            empty
);
	import grap_pkg::*;

	item_t              mem_q [FIFO_DEPTH];
	logic [FIFO_AW-1:0] wr_q;
	logic [FIFO_AW-1:0] rd_q;
	logic [FIFO_AW:0]   cnt_q;

	assign full  = (cnt_q == (FIFO_AW+1)'(FIFO_DEPTH));
	assign empty = (cnt_q == '0);
	assign rdata = mem_q[rd_q];

	// Storage
	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_q] <= wdata;
		end
	end

	// Pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (push) begin
				wr_q <= wr_q + 1'b1;
			end
			if (pop) begin
				rd_q <= rd_q + 1'b1;
			end
			if (push && !pop) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (pop && !push) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

endmodule

// ===== hw/rtl/grap_cordic_rot.sv =====
// Pipelined circular CORDIC in rotation mode, one iteration per stage.
// Depends on grap_pkg.
module grap_cordic_rot (
	input  logic                           clk,
	input  logic                           en,
	input  logic signed [grap_pkg::CW-1:0] x_in,
	input  logic signed [grap_pkg::CW-1:0] y_in,
	input  logic signed [31:0]             z_in,
	output logic signed [grap_pkg::CW-1:0] x_out,
	output logic signed [grap_pkg::CW-1:0] y_out
);
	import grap_pkg::*;

	logic signed [CW-1:0] x0, y0, z0, zi;
	logic signed [CW-1:0] x_q [CORDIC_STEPS];
	logic signed [CW-1:0] y_q [CORDIC_STEPS];
	logic signed [CW-1:0] z_q [CORDIC_STEPS];
	logic signed [CW-1:0] xc [CORDIC_STEPS];
	logic signed [CW-1:0] yc [CORDIC_STEPS];
	logic signed [CW-1:0] zc [CORDIC_STEPS];

	// Fold the angle into the right half plane
	always_comb begin
		zi = CW'(z_in);
		x0 = x_in;
		y0 = y_in;
		z0 = zi;
		if (zi > ANG_QUARTER) begin
			x0 = -x_in;
			y0 = -y_in;
			z0 = zi - ANG_HALF;
		end else if (zi < -ANG_QUARTER) begin
			x0 = -x_in;
			y0 = -y_in;
			z0 = zi + ANG_HALF;
		end
	end

	// Iteration stages
	for (genvar i = 0; i < CORDIC_STEPS; i++) begin : g_step
		localparam logic signed [CW-1:0] ATAN = $signed({2'b00, ATAN_TAB[i]});
		if (i == 0) begin : g_first
			assign xc[i] = x0;
			assign yc[i] = y0;
			assign zc[i] = z0;
		end else begin : g_next
			assign xc[i] = x_q[i-1];
			assign yc[i] = y_q[i-1];
			assign zc[i] = z_q[i-1];
		end
		always_ff @(posedge clk) begin
			if (en) begin
				if (zc[i] >= 0) begin
					x_q[i] <= xc[i] - (yc[i] >>> i);
					y_q[i] <= yc[i] + (xc[i] >>> i);
					z_q[i] <= zc[i] - ATAN;
				end else begin
					x_q[i] <= xc[i] + (yc[i] >>> i);
					y_q[i] <= yc[i] - (xc[i] >>> i);
					z_q[i] <= zc[i] + ATAN;
				end
			end
		end
	end

	assign x_out = x_q[CORDIC_STEPS-1];
	assign y_out = y_q[CORDIC_STEPS-1];

endmodule

// ===== hw/rtl/grap_cordic_vec.sv =====
// Pipelined circular CORDIC in vectoring mode: angle and gain-scaled magnitude.
// Depends on grap_pkg.
module grap_cordic_vec (
	input  logic                           clk,
	input  logic                           en,
	input  logic signed [grap_pkg::CW-1:0] x_in,
	input  logic signed [grap_pkg::CW-1:0] y_in,
	output logic signed [grap_pkg::CW-1:0] mag,
	output logic [31:0]                    angle
);
	import grap_pkg::*;

	logic signed [CW-1:0] x0, y0, z0;
	logic signed [CW-1:0] x_q [CORDIC_STEPS];
	logic signed [CW-1:0] y_q [CORDIC_STEPS];
	logic signed [CW-1:0] z_q [CORDIC_STEPS];
	logic signed [CW-1:0] xc [CORDIC_STEPS];
	logic signed [CW-1:0] yc [CORDIC_STEPS];
	logic signed [CW-1:0] zc [CORDIC_STEPS];

	// Mirror the left half plane onto the right
	always_comb begin
		x0 = x_in;
		y0 = y_in;
		z0 = '0;
		if (x_in < 0) begin
			x0 = -x_in;
			y0 = -y_in;
			z0 = ANG_HALF;
		end
	end

	// Iteration stages
	for (genvar i = 0; i < CORDIC_STEPS; i++) begin : g_step
		localparam logic signed [CW-1:0] ATAN = $signed({2'b00, ATAN_TAB[i]});
		if (i == 0) begin : g_first
			assign xc[i] = x0;
			assign yc[i] = y0;
			assign zc[i] = z0;
		end else begin : g_next
			assign xc[i] = x_q[i-1];
			assign yc[i] = y_q[i-1];
			assign zc[i] = z_q[i-1];
		end
		always_ff @(posedge clk) begin
			if (en) begin
				if (yc[i] > 0) begin
					x_q[i] <= xc[i] + (yc[i] >>> i);
					y_q[i] <= yc[i] - (xc[i] >>> i);
					z_q[i] <= zc[i] + ATAN;
				end else begin
					x_q[i] <= xc[i] - (yc[i] >>> i);
					y_q[i] <= yc[i] + (xc[i] >>> i);
					z_q[i] <= zc[i] - ATAN;
				end
			end
		end
	end

	assign mag   = x_q[CORDIC_STEPS-1];
	assign angle = z_q[CORDIC_STEPS-1][31:0];

endmodule

// ===== hw/rtl/grap_exp.sv =====
// Pipelined Gaussian factor exp(-u*k) in Q0.31 with the amplitude carried alongside.
// Depends on grap_pkg.
module grap_exp (
	input  logic               clk,
	input  logic               en,
	input  logic [61:0]        u,
	input  logic [31:0]        k,
	input  logic signed [32:0] amp_in,
	output logic [31:0]        g,
	output logic signed [32:0] amp_out
);
	import grap_pkg::*;

	typedef struct packed {
		logic signed [33:0] sum;
		logic [30:0]        f;
		logic [4:0]         n;
		logic               big;
		logic               kz;
		logic signed [32:0] amp;
	} side_t;

	// Exponent product, split into two partial products
	logic [63:0]        pl_s1;
	logic [61:0]        ph_s1;
	logic               kz_s1;
	logic signed [32:0] amp_s1;
	logic [93:0]        xsum;
	side_t              side_s2;

	always_ff @(posedge clk) begin
		if (en) begin
			pl_s1  <= u[31:0] * k;
			ph_s1  <= u[61:32] * k;
			kz_s1  <= (k == '0);
			amp_s1 <= amp_in;
		end
	end

	assign xsum = {ph_s1, 32'h0} + {30'h0, pl_s1};

	// Range check and split into whole and fractional parts
	always_ff @(posedge clk) begin
		if (en) begin
			side_s2.sum <= 34'sd2147483648;
			side_s2.f   <= xsum[47:17];
			side_s2.n   <= xsum[52:48];
			side_s2.big <= (xsum > 94'd4503599627370496);
			side_s2.kz  <= kz_s1;
			side_s2.amp <= amp_s1;
		end
	end

	// Taylor series, three stages per term
	logic [62:0] p_q    [EXP_TERMS];
	logic [31:0] t_q    [EXP_TERMS];
	logic [68:0] pr_q   [EXP_TERMS];
	logic [31:0] term_q [EXP_TERMS];
	side_t       sa_q   [EXP_TERMS];
	side_t       sb_q   [EXP_TERMS];
	side_t       sc_q   [EXP_TERMS];
	logic [31:0] term_in [EXP_TERMS];
	side_t       side_in [EXP_TERMS];

	for (genvar t = 0; t < EXP_TERMS; t++) begin : g_term
		localparam int          K     = t + 1;
		localparam logic [36:0] RECIP = 37'((64'd1 << 36) / K);
		logic [31:0] q0;
		logic [35:0] rem;
		logic [31:0] q;
		side_t       sn;

		if (t == 0) begin : g_first
			assign term_in[t] = 32'h8000_0000;
			assign side_in[t] = side_s2;
		end else begin : g_next
			assign term_in[t] = term_q[t-1];
			assign side_in[t] = sc_q[t-1];
		end

		// term times fraction
		always_ff @(posedge clk) begin
			if (en) begin
				p_q[t]  <= term_in[t] * side_in[t].f;
				sa_q[t] <= side_in[t];
			end
		end

		// scale down and multiply by the reciprocal of K
		always_ff @(posedge clk) begin
			if (en) begin
				t_q[t]  <= p_q[t][62:31];
				pr_q[t] <= p_q[t][62:31] * RECIP;
				sb_q[t] <= sa_q[t];
			end
		end

		// quotient correction and accumulate with alternating sign
		assign q0  = pr_q[t][67:36];
		assign rem = {4'h0, t_q[t]} - q0 * 36'(K);
		assign q   = q0 + 32'(rem >= 36'(K));

		always_comb begin
			sn = sb_q[t];
			if (K % 2 == 1) begin
				sn.sum = sb_q[t].sum - $signed({2'b00, q});
			end else begin
				sn.sum = sb_q[t].sum + $signed({2'b00, q});
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				term_q[t] <= q;
				sc_q[t]   <= sn;
			end
		end
	end

	// Clamp the series to [0, 1]
	logic [31:0] gc_s3;
	side_t       sd_s3;
	side_t       last_side;

	assign last_side = sc_q[EXP_TERMS-1];

	always_ff @(posedge clk) begin
		if (en) begin
			sd_s3 <= last_side;
			if (last_side.sum < 0) begin
				gc_s3 <= '0;
			end else if (last_side.sum > 34'sd2147483648) begin
				gc_s3 <= 32'h8000_0000;
			end else begin
				gc_s3 <= last_side.sum[31:0];
			end
		end
	end

	// One multiply by e^-1 per whole unit of the exponent
	logic [31:0] pg_q [EXP_POWS];
	side_t       ps_q [EXP_POWS];
	logic [31:0] pg_in [EXP_POWS];
	side_t       ps_in [EXP_POWS];

	for (genvar j = 0; j < EXP_POWS; j++) begin : g_pow
		logic [61:0] prod;
		if (j == 0) begin : g_first
			assign pg_in[j] = gc_s3;
			assign ps_in[j] = sd_s3;
		end else begin : g_next
			assign pg_in[j] = pg_q[j-1];
			assign ps_in[j] = ps_q[j-1];
		end
		assign prod = pg_in[j] * EINV_Q31;
		always_ff @(posedge clk) begin
			if (en) begin
				ps_q[j] <= ps_in[j];
				if (5'(j) < ps_in[j].n) begin
					pg_q[j] <= 32'(prod[61:31]);
				end else begin
					pg_q[j] <= pg_in[j];
				end
			end
		end
	end

	// Zero exponent gives one; an exponent beyond sixteen gives zero
	always_comb begin
		if (ps_q[EXP_POWS-1].kz) begin
			g = 32'h8000_0000;
		end else if (ps_q[EXP_POWS-1].big) begin
			g = '0;
		end else begin
			g = pg_q[EXP_POWS-1];
		end
	end

	assign amp_out = ps_q[EXP_POWS-1].amp;

endmodule
